[rtl/jsu_pkg.sv]
// types, codes and helpers shared by the json string unescape unit
`timescale 1ns / 1ps
package jsu_pkg;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESCAPE = 2'd1;
  localparam logic [1:0] MODE_HEX    = 2'd2;
  localparam logic [1:0] MODE_DONE   = 2'd3;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } jsu_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last_of_run;
  } jsu_out_t;

  // results caused by one input item, first byte in slot 0
  typedef struct packed {
    logic [1:0]      cnt;
    logic [1:0]      kind;
    logic [2:0][7:0] bytes;
  } jsu_run_t;

  // bit 4 set when the character is not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
    return v;
  endfunction

endpackage

[rtl/jsu_front.sv]
// front end: escape parser that turns each input request into a run of results
`timescale 1ns / 1ps
module jsu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  jsu_pkg::jsu_in_t  req,
  output logic              run_push,
  output jsu_pkg::jsu_run_t run
);

  logic [1:0]  mode_r, mode_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [15:0] code_r, code_nxt;
  logic [4:0]  hv;
  logic [15:0] code_cat;

  always_comb begin
    run         = '0;
    mode_nxt    = mode_r;
    hex_cnt_nxt = hex_cnt_r;
    code_nxt    = code_r;
    hv          = jsu_pkg::hex_val(req.text_byte);
    code_cat    = {code_r[11:0], hv[3:0]};
    if (req.text_end) begin
      case (mode_r)
        jsu_pkg::MODE_NORMAL: begin
          run.cnt  = 2'd1;
          run.kind = jsu_pkg::KIND_DONE;
        end
        jsu_pkg::MODE_ESCAPE, jsu_pkg::MODE_HEX: begin
          run.cnt  = 2'd1;
          run.kind = jsu_pkg::KIND_ERROR;
        end
        default: ;
      endcase
      mode_nxt    = jsu_pkg::MODE_NORMAL;
      hex_cnt_nxt = 2'd0;
      code_nxt    = 16'd0;
    end else begin
      case (mode_r)
        jsu_pkg::MODE_NORMAL: begin
          if (req.text_byte == 8'h22) begin
            run.cnt  = 2'd1;
            run.kind = jsu_pkg::KIND_DONE;
            mode_nxt = jsu_pkg::MODE_DONE;
          end else if (req.text_byte == 8'h5c) begin
            mode_nxt = jsu_pkg::MODE_ESCAPE;
          end else begin
            run.cnt      = 2'd1;
            run.kind     = jsu_pkg::KIND_BYTE;
            run.bytes[0] = req.text_byte;
          end
        end
        jsu_pkg::MODE_ESCAPE: begin
          run.cnt  = 2'd1;
          run.kind = jsu_pkg::KIND_BYTE;
          mode_nxt = jsu_pkg::MODE_NORMAL;
          case (req.text_byte)
            8'h22: run.bytes[0] = 8'h22;
            8'h5c: run.bytes[0] = 8'h5c;
            8'h2f: run.bytes[0] = 8'h2f;
            8'h62: run.bytes[0] = 8'h08;
            8'h66: run.bytes[0] = 8'h0c;
            8'h6e: run.bytes[0] = 8'h0a;
            8'h72: run.bytes[0] = 8'h0d;
            8'h74: run.bytes[0] = 8'h09;
            8'h75: begin
              run.cnt     = 2'd0;
              mode_nxt    = jsu_pkg::MODE_HEX;
              hex_cnt_nxt = 2'd0;
              code_nxt    = 16'd0;
            end
            default: begin
              run.kind = jsu_pkg::KIND_ERROR;
              mode_nxt = jsu_pkg::MODE_DONE;
            end
          endcase
        end
        jsu_pkg::MODE_HEX: begin
          if (hv[4]) begin
            run.cnt  = 2'd1;
            run.kind = jsu_pkg::KIND_ERROR;
            mode_nxt = jsu_pkg::MODE_DONE;
          end else if (hex_cnt_r == 2'd3) begin
            run.kind = jsu_pkg::KIND_BYTE;
            if (code_cat[15:7] == 9'd0) begin
              run.cnt      = 2'd1;
              run.bytes[0] = code_cat[7:0];
            end else if (code_cat[15:11] == 5'd0) begin
              run.cnt      = 2'd2;
              run.bytes[0] = {3'b110, code_cat[10:6]};
              run.bytes[1] = {2'b10, code_cat[5:0]};
            end else begin
              run.cnt      = 2'd3;
              run.bytes[0] = {4'b1110, code_cat[15:12]};
              run.bytes[1] = {2'b10, code_cat[11:6]};
              run.bytes[2] = {2'b10, code_cat[5:0]};
            end
            mode_nxt    = jsu_pkg::MODE_NORMAL;
            hex_cnt_nxt = 2'd0;
            code_nxt    = 16'd0;
          end else begin
            hex_cnt_nxt = hex_cnt_r + 2'd1;
            code_nxt    = code_cat;
          end
        end
        default: ;
      endcase
    end
  end

  assign run_push = accept && (run.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= jsu_pkg::MODE_NORMAL;
      hex_cnt_r <= 2'd0;
      code_r    <= 16'd0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      code_r    <= code_nxt;
    end
  end

endmodule

[rtl/jsu_queue.sv]
// short run queue between the parser and the result sequencer
`timescale 1ns / 1ps
module jsu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  jsu_pkg::jsu_run_t wdata,
  input  logic              pop,
  output jsu_pkg::jsu_run_t rdata,
  output logic              full,
  output logic              empty
);

  jsu_pkg::jsu_run_t               mem_r [jsu_pkg::QDEPTH];
  logic [jsu_pkg::QPTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [jsu_pkg::QCNT_W-1:0]      cnt_r;
  logic                            do_push, do_pop;

  assign full    = (cnt_r == jsu_pkg::QCNT_W'(jsu_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + jsu_pkg::QPTR_W'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + jsu_pkg::QPTR_W'(1);
      if (do_push && !do_pop) cnt_r <= cnt_r + jsu_pkg::QCNT_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - jsu_pkg::QCNT_W'(1);
    end
  end

endmodule

[rtl/jsu_back.sv]
// back end: plays out each queued run one result per cycle while out_pop is high
`timescale 1ns / 1ps
module jsu_back (
  input  logic              clk,
  input  logic              rst_n,
  input  jsu_pkg::jsu_run_t q_head,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output jsu_pkg::jsu_out_t out_req
);

  jsu_pkg::jsu_run_t cur_r;
  logic              cur_valid_r;
  logic [1:0]        idx_r;
  logic              take, fin, is_last;

  assign is_last = (idx_r == cur_r.cnt - 2'd1);
  assign take    = out_pop && cur_valid_r;
  assign fin     = take && is_last;
  assign q_pop   = (!cur_valid_r || fin) && !q_empty;

  assign out_empty           = !cur_valid_r;
  assign out_req.out_byte    = cur_r.bytes[idx_r];
  assign out_req.kind        = cur_r.kind;
  assign out_req.last_of_run = is_last;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= 2'd0;
    end else if (fin) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (take) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (idx_r < cur_r.cnt))
    else $error("result index past end of run");

  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cur_r.cnt != 2'd0))
    else $error("empty run loaded");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (fin && q_empty) |=> out_empty)
    else $error("result shown after run drained");

  a_no_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r && !out_pop) |=> (cur_valid_r && $stable(idx_r)))
    else $error("result lost while stalled");

endmodule

[rtl/json_string_unescape_utf8_unit.sv]
// top level of the json string unescape unit with utf-8 encoding of \u escapes
`timescale 1ns / 1ps
// Takes one text byte per cycle while not full (push/full) and gives decoded
// bytes, completion and error results one per cycle (empty/pop). The parser
// turns each request into a run of zero to three results in the same cycle it
// is accepted; runs wait in a four-entry queue and the result stage plays them
// out, so a \u escape that needs three UTF-8 bytes occupies the output for all
// three while input keeps flowing until the queue fills. An accepted byte's
// first result passes through a queue entry and then the result stage register
// before it shows.
module json_string_unescape_utf8_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  jsu_pkg::jsu_in_t  in_req,
  output logic              out_empty,
  input  logic              out_pop,
  output jsu_pkg::jsu_out_t out_req
);

  jsu_pkg::jsu_run_t run, q_head;
  logic              run_push, q_pop, q_empty, accept;

  assign accept = in_push && !in_full;

  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .req      (in_req),
    .run_push (run_push),
    .run      (run)
  );

  jsu_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (run_push),
    .wdata (run),
    .pop   (q_pop),
    .rdata (q_head),
    .full  (in_full),
    .empty (q_empty)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_req   (out_req)
  );

endmodule
